### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is asserted (active low).
`define KS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define KS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KS_ASSERT(lbl, clk, rstn, prop, msg)
`define KS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hdl/ksnap_pkg.sv
package ksnap_pkg;

    typedef logic signed [63:0] key_t;

    // Operation codes carried on s_tuser.
    localparam logic [2:0] FN_CLEAR   = 3'd0;
    localparam logic [2:0] FN_APPEND  = 3'd1;
    localparam logic [2:0] FN_BEFORE  = 3'd2;
    localparam logic [2:0] FN_AFTER   = 3'd3;
    localparam logic [2:0] FN_NEAREST = 3'd4;
    localparam logic [2:0] FN_RANGE   = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    localparam key_t KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic start;
        logic strict;
        key_t key;
    } search_req_t;

    typedef struct packed {
        logic done;
        logic lo_zero;
        logic lo_end;
        key_t below;
        key_t at;
    } search_resp_t;

    function automatic key_t min_key(input key_t a, input key_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

### hdl/ksnap_table.sv
module ksnap_table import ksnap_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  key_t          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output key_t          rd_data
);

    key_t mem [DEPTH];
    key_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/ksnap_search.sv
module ksnap_search import ksnap_pkg::*; #(
    parameter int AW = 12,
    parameter int CW = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  search_req_t   req,
    input  logic [CW-1:0] count,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  key_t          rd_data,
    output search_resp_t  resp
);

    // Binary search for the first entry >= key (> key when strict), probing in
    // E_PROBE and E_CMP, then the entries just below and at the found index are read.
    localparam logic [2:0] E_IDLE  = 3'd0;
    localparam logic [2:0] E_PROBE = 3'd1;
    localparam logic [2:0] E_CMP   = 3'd2;
    localparam logic [2:0] E_BEL   = 3'd3;
    localparam logic [2:0] E_AT    = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0] cnt_reg, cnt_next, mid_c, lo_m1;
    key_t          key_reg, key_next, below_reg, below_next;
    logic          strict_reg, strict_next;

    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1 = lo_reg - 1'b1;

    always_comb begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        strict_next = strict_reg;
        below_next  = below_reg;
        rd_en       = 1'b0;
        rd_addr     = mid_c[AW-1:0];
        case (state_reg)
            E_IDLE: begin
                if (req.start) begin
                    lo_next     = '0;
                    hi_next     = count;
                    cnt_next    = count;
                    key_next    = req.key;
                    strict_next = req.strict;
                    state_next  = E_PROBE;
                end
            end
            E_PROBE: begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_c;
                    state_next = E_CMP;
                end else begin
                    rd_addr    = lo_m1[AW-1:0];
                    state_next = E_BEL;
                end
            end
            E_CMP: begin
                if (rd_data < key_reg || (strict_reg && rd_data == key_reg)) begin
                    lo_next = mid_reg + 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = E_PROBE;
            end
            E_BEL: begin
                below_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = lo_reg[AW-1:0];
                state_next = E_AT;
            end
            E_AT: begin
                state_next = E_IDLE;
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        cnt_reg    <= cnt_next;
        key_reg    <= key_next;
        strict_reg <= strict_next;
        below_reg  <= below_next;
    end

    assign resp.done    = (state_reg == E_AT);
    assign resp.lo_zero = (lo_reg == '0);
    assign resp.lo_end  = (lo_reg >= cnt_reg);
    assign resp.below   = below_reg;
    assign resp.at      = rd_data;

endmodule

### hdl/keyframe_snap_search.sv
// Channel   Direction  Handshake              Contents
// s_        in         s_tvalid / s_tready    item: op code, time_a, time_b
// m_        out        m_tvalid / m_tready    item: result_a, result_b, status
// cfg_      in         cfg_valid / cfg_ready  clip_duration write
//
// Clear, append and unused op codes go straight from T_IDLE to T_OUT; m_tvalid is registered.
// A snap query is one binary search: at most ceil(log2(count+1)) probes, then a fetch
// of the neighbors just below and at the found index.
// A range query runs up to three searches.
// Reset clears the entry count, the clip length and the output; the table is not cleared.
// s_tready is high whenever the sequencer idles; a waiting result holds the next item.
`include "assert_macros.svh"

module keyframe_snap_search import ksnap_pkg::*; #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: clip_duration.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [62:0]  cfg_data,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] time_a, [127:64] time_b
    input  logic [2:0]   s_tuser,   // [2:0] func
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // [63:0] result_a, [127:64] result_b,
                                    // [129:128] status, [135:130] zero
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Top-level sequencer states.
    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_CLAMP  = 3'd1;
    localparam logic [2:0] T_LAUNCH = 3'd2;
    localparam logic [2:0] T_WAIT   = 3'd3;
    localparam logic [2:0] T_NEAR   = 3'd4;
    localparam logic [2:0] T_WIDE   = 3'd5;
    localparam logic [2:0] T_OUT    = 3'd6;

    // What the running search is for.
    localparam logic [2:0] P_BEFORE    = 3'd0;
    localparam logic [2:0] P_AFTER     = 3'd1;
    localparam logic [2:0] P_NEAR      = 3'd2;
    localparam logic [2:0] P_RANGE_IN  = 3'd3;
    localparam logic [2:0] P_RANGE_OUT = 3'd4;
    localparam logic [2:0] P_RANGE_WID = 3'd5;

    logic [2:0]    state_reg, state_next, phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [62:0]   clip_reg;
    key_t          last_key_reg, last_key_next;
    key_t          key_reg, key_next, end_reg, end_next, out_c_reg, out_c_next;
    key_t          a_reg, a_next, b_reg, b_next, bel_reg, bel_next, aft_reg, aft_next;
    logic [63:0]   dl_reg, dl_next, dr_reg, dr_next;
    key_t          ra_reg, ra_next, rb_reg, rb_next;
    logic [1:0]    st_reg, st_next;
    logic          m_valid_reg, m_valid_next;
    key_t          res_a_reg, res_b_reg;
    logic [1:0]    res_st_reg;
    logic          res_load;

    logic          s_acc;
    logic [2:0]    in_func;
    key_t          in_ta, in_tb;
    logic [1:0]    app_status;
    logic          wr_en;

    search_req_t   req;
    search_resp_t  resp;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    key_t          rd_data;

    logic          empty;
    key_t          clip_end, v_before, v_after, a_clamp, in_c, out_c;

    assign in_func = s_tuser;
    assign in_ta   = key_t'(s_tdata[63:0]);
    assign in_tb   = key_t'(s_tdata[127:64]);
    assign s_acc   = s_tvalid && s_tready;

    assign s_tready  = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;

    // Append is rejected when the table is full, then when it is not ascending.
    always_comb begin
        if (count_reg >= CW'(TABLE_DEPTH)) begin
            app_status = ST_FULL;
        end else if (count_reg != '0 && in_ta <= last_key_reg) begin
            app_status = ST_ORDER;
        end else begin
            app_status = ST_OK;
        end
    end

    assign wr_en = s_acc && in_func == FN_APPEND && app_status == ST_OK;

    ksnap_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_ta),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.start  = (state_reg == T_LAUNCH);
    assign req.strict = (phase_reg == P_BEFORE) || (phase_reg == P_RANGE_IN);
    assign req.key    = key_reg;

    ksnap_search #(
        .AW (AW),
        .CW (CW)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .count   (count_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .resp    (resp)
    );

    // Snap values from a finished search. With an empty table the search
    // returns nothing useful and the query time itself is used.
    assign empty = (count_reg == '0);

    always_comb begin
        if (empty) begin
            v_before = key_reg;
        end else if (resp.lo_zero) begin
            v_before = (resp.at <= 0) ? resp.at : '0;
        end else begin
            v_before = resp.below;
        end
        if (empty) begin
            v_after = min_key(key_reg, end_reg);
        end else if (resp.lo_end) begin
            v_after = end_reg;
        end else begin
            v_after = min_key(resp.at, end_reg);
        end
    end

    assign a_clamp = (v_before < 0) ? '0 : v_before;

    // Range clamping against the clip end; a negative out time means the end.
    assign clip_end = key_t'({1'b0, clip_reg});
    assign out_c    = (out_c_reg < 0 || out_c_reg > clip_end) ? clip_end : out_c_reg;
    assign in_c     = (key_reg < 0) ? '0 : ((key_reg > clip_end) ? clip_end : key_reg);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        last_key_next = last_key_reg;
        key_next      = key_reg;
        end_next      = end_reg;
        out_c_next    = out_c_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        bel_next      = bel_reg;
        aft_next      = aft_reg;
        dl_next       = dl_reg;
        dr_next       = dr_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        st_next       = st_reg;
        res_load      = 1'b0;
        case (state_reg)
            T_IDLE: begin
                if (s_acc) begin
                    ra_next    = '0;
                    rb_next    = '0;
                    st_next    = ST_OK;
                    key_next   = in_ta;
                    end_next   = in_tb;
                    out_c_next = in_tb;
                    state_next = T_OUT;
                    case (in_func)
                        FN_CLEAR: begin
                            count_next = '0;
                        end
                        FN_APPEND: begin
                            st_next = app_status;
                            if (app_status == ST_OK) begin
                                count_next    = count_reg + 1'b1;
                                last_key_next = in_ta;
                            end
                        end
                        FN_BEFORE: begin
                            phase_next = P_BEFORE;
                            state_next = T_LAUNCH;
                        end
                        FN_AFTER: begin
                            phase_next = P_AFTER;
                            state_next = T_LAUNCH;
                        end
                        FN_NEAREST: begin
                            phase_next = P_NEAR;
                            state_next = T_LAUNCH;
                        end
                        FN_RANGE: begin
                            state_next = T_CLAMP;
                        end
                        default: begin
                            state_next = T_OUT;
                        end
                    endcase
                end
            end
            T_CLAMP: begin
                key_next   = in_c;
                out_c_next = out_c;
                end_next   = clip_end;
                phase_next = P_RANGE_IN;
                state_next = T_LAUNCH;
            end
            T_LAUNCH: begin
                state_next = T_WAIT;
            end
            T_WAIT: begin
                if (resp.done) begin
                    state_next = T_OUT;
                    case (phase_reg)
                        P_BEFORE: begin
                            ra_next = v_before;
                        end
                        P_AFTER: begin
                            ra_next = v_after;
                        end
                        P_NEAR: begin
                            if (empty) begin
                                ra_next = key_reg;
                            end else if (resp.lo_end) begin
                                ra_next = resp.below;
                            end else if (resp.lo_zero) begin
                                ra_next = resp.at;
                            end else begin
                                // Distances on both sides, compared next cycle.
                                bel_next   = resp.below;
                                aft_next   = resp.at;
                                dl_next    = 64'(key_reg) - 64'(resp.below);
                                dr_next    = 64'(resp.at) - 64'(key_reg);
                                state_next = T_NEAR;
                            end
                        end
                        P_RANGE_IN: begin
                            a_next = a_clamp;
                            if (out_c_reg >= end_reg) begin
                                b_next     = end_reg;
                                state_next = T_WIDE;
                            end else begin
                                key_next   = out_c_reg;
                                phase_next = P_RANGE_OUT;
                                state_next = T_LAUNCH;
                            end
                        end
                        P_RANGE_OUT: begin
                            b_next     = v_after;
                            state_next = T_WIDE;
                        end
                        P_RANGE_WID: begin
                            ra_next = a_reg;
                            rb_next = v_after;
                        end
                        default: begin
                            state_next = T_OUT;
                        end
                    endcase
                end
            end
            T_NEAR: begin
                // Ties go to the earlier keyframe.
                ra_next    = (dl_reg <= dr_reg) ? bel_reg : aft_reg;
                state_next = T_OUT;
            end
            T_WIDE: begin
                if (b_reg <= a_reg) begin
                    // Empty range: snap the out point forward from just past in.
                    key_next   = (a_reg == KEY_MAX) ? a_reg : a_reg + 64'sd1;
                    phase_next = P_RANGE_WID;
                    state_next = T_LAUNCH;
                end else begin
                    ra_next    = a_reg;
                    rb_next    = b_reg;
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    res_load   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            count_reg   <= '0;
            clip_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                clip_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg    <= phase_next;
        last_key_reg <= last_key_next;
        key_reg      <= key_next;
        end_reg      <= end_next;
        out_c_reg    <= out_c_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        bel_reg      <= bel_next;
        aft_reg      <= aft_next;
        dl_reg       <= dl_next;
        dr_reg       <= dr_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        st_reg       <= st_next;
        if (res_load) begin
            res_a_reg  <= ra_reg;
            res_b_reg  <= rb_reg;
            res_st_reg <= st_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, res_st_reg, res_b_reg, res_a_reg};

    // A successful append grows the table by exactly one entry.
    `KS_ASSERT(a_append_count, aclk, aresetn, (s_acc && in_func == FN_APPEND && app_status == ST_OK) |=> (count_reg == $past(count_reg) + 1'b1), "append did not advance the entry count")
    // The search engine only finishes while the sequencer waits for it.
    `KS_ASSERT(a_search_owner, aclk, aresetn, resp.done |-> (state_reg == T_WAIT), "search finished outside the wait state")
    // The entry count never runs past the table depth.
    `KS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(TABLE_DEPTH), "entry count exceeds table depth")
    // A new item is never taken while a search is running.
    `KS_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg == T_WAIT) |-> !s_acc, "item accepted during a search")

endmodule
